>>> rtl/rsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack calculator package
// Shared types, command and status codes and fixed-point constants.
// ----------------------------------------------------------------------------
package rsc_pkg;

  // Stack geometry and number format (signed Q16.16)
  localparam int unsigned STACK_DEPTH_DEF = 8;
  localparam int unsigned Q_W             = 32;
  localparam int unsigned FRAC_W          = 16;
  localparam int unsigned DEPTH_OUT_W     = 4;

  localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

  // Divider: magnitude of dividend * 2^16, two quotient bits per cycle
  localparam int unsigned DIV_N_W   = Q_W + FRAC_W;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_ITERS = DIV_N_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_ITERS);

  // Command codes
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_DROP = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIV0 = 2'd3
  } status_e;

  // Per-cycle move command broadcast to every stack cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN
  } cell_cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV
  } state_e;

  // Request payload
  typedef struct packed {
    logic [2:0]            op;
    logic signed [Q_W-1:0] push_value;
  } req_t;

  // Result payload
  typedef struct packed {
    logic signed [Q_W-1:0]   top_value;
    logic [DEPTH_OUT_W-1:0]  stack_depth;
    logic [1:0]              status;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/rsc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack cell
// One stack entry; takes its upper or lower neighbor's value on a shift.
// ----------------------------------------------------------------------------
module rsc_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rsc_pkg::cell_cmd_e            cmd_i,
  input  wire logic signed [rsc_pkg::Q_W-1:0] prev_i,  // entry nearer the top
  input  wire logic signed [rsc_pkg::Q_W-1:0] next_i,  // entry nearer the bottom
  output logic signed [rsc_pkg::Q_W-1:0]      data_o
);

  logic signed [rsc_pkg::Q_W-1:0] data_q, data_d;

  // Select the new content
  always_comb begin
    case (cmd_i)
      rsc_pkg::CELL_UP:   data_d = prev_i;
      rsc_pkg::CELL_DOWN: data_d = next_i;
      default:            data_d = data_q;
    endcase
  end

  // Entry register, empty slots read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

>>> rtl/rsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN unsigned divider
// Restoring radix-2 divider, two quotient bits per cycle, 48-bit dividend.
// ----------------------------------------------------------------------------
module rsc_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [rsc_pkg::DIV_N_W-1:0]     dividend_i,
  input  wire logic [rsc_pkg::Q_W-1:0]         divisor_i,
  output logic                                 done_o,
  output logic [rsc_pkg::DIV_N_W-1:0]          quot_o
);

  localparam logic [rsc_pkg::DIV_CNT_W-1:0] LastIter =
    rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_ITERS - 1);

  logic                               run_q, done_q;
  logic [rsc_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic [rsc_pkg::Q_W-1:0]            rem_q, rem_d;
  logic [rsc_pkg::Q_W-1:0]            dvs_q;
  logic [rsc_pkg::DIV_N_W-1:0]        quo_q, quo_d;

  // Two dependent shift-compare-subtract steps
  always_comb begin
    logic [rsc_pkg::Q_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int k = 0; k < rsc_pkg::DIV_STEPS; k++) begin
      trial = {rem_d, quo_d[rsc_pkg::DIV_N_W-1]};
      quo_d = {quo_d[rsc_pkg::DIV_N_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[rsc_pkg::Q_W-1:0];
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastIter) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: dividend shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> rtl/rpn_stack_calculator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RPN stack calculator core
// Signed Q16.16 operand stack built as a row of shift cells with a command
// sequencer, a registered multiplier and an iterative divider.
// ----------------------------------------------------------------------------
// A request is taken on a clock edge where start is high and busy is low;
// one result follows per request on res_o, flagged by done_o for exactly one
// cycle, and it must be captured then since it cannot be held off. Push,
// add, subtract, drop and unused codes finish in the execute state, multiply
// goes on to a multiply state (product register, then shift and saturate),
// and divide waits on the 48-bit divider that produces two quotient bits per
// cycle; a divide by zero skips the divider and finishes in the execute state.
// busy is low again in the cycle done_o is high, so a new request may be
// issued alongside a result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rsc_pkg::req_t req_i,
  output logic               done_o,
  output rsc_pkg::res_t      res_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QW   = rsc_pkg::Q_W;

  rsc_pkg::state_e            state_q, state_d;
  rsc_pkg::req_t              req_q;
  rsc_pkg::status_e           status_q, status_d;
  rsc_pkg::cell_cmd_e         cell_cmd;
  logic [CntW-1:0]            cnt_q, cnt_d, cnt_dec;
  logic [CntW+3:0]            cnt_ext;
  logic                       done_q, done_d;
  logic signed [2*QW-1:0]     prod_q, prod_d;
  logic signed [QW-1:0]       cell_data [STACK_DEPTH];
  logic signed [QW-1:0]       top0_load;
  logic signed [QW-1:0]       opa, opb;
  logic [QW:0]                sum;
  logic [QW-1:0]              a_mag, b_mag;
  logic                       div_start, div_done;
  logic [rsc_pkg::DIV_N_W-1:0] quot;

  // Stack cells: entry 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [QW-1:0] prev_val, next_val;
    if (i == 0) begin : g_top
      assign prev_val = req_q.push_value;
      assign next_val = top0_load;
    end else if (i == STACK_DEPTH - 1) begin : g_bottom
      assign prev_val = cell_data[i-1];
      assign next_val = '0;
    end else begin : g_mid
      assign prev_val = cell_data[i-1];
      assign next_val = cell_data[i+1];
    end
    rsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cell_cmd),
      .prev_i (prev_val),
      .next_i (next_val),
      .data_o (cell_data[i])
    );
  end

  // Operands: second entry op top
  assign opa     = cell_data[1];
  assign opb     = cell_data[0];
  assign a_mag   = opa[QW-1] ? (QW'(0) - opa) : opa;
  assign b_mag   = opb[QW-1] ? (QW'(0) - opb) : opb;
  assign cnt_dec = (cnt_q != '0) ? (cnt_q - 1'b1) : cnt_q;

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({a_mag, rsc_pkg::FRAC_W'(0)}),
    .divisor_i  (b_mag),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sequencer: next state, cell moves and result status
  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    cell_cmd  = rsc_pkg::CELL_HOLD;
    top0_load = cell_data[1];
    prod_d    = prod_q;
    div_start = 1'b0;
    sum       = '0;
    case (state_q)
      rsc_pkg::S_IDLE: begin
        if (start) begin
          state_d = rsc_pkg::S_EXEC;
        end
      end
      rsc_pkg::S_EXEC: begin
        state_d  = rsc_pkg::S_IDLE;
        done_d   = 1'b1;
        status_d = rsc_pkg::ST_OK;
        case (req_q.op)
          rsc_pkg::OP_PUSH: begin
            if (cnt_q < CntW'(STACK_DEPTH)) begin
              cell_cmd = rsc_pkg::CELL_UP;
              cnt_d    = cnt_q + 1'b1;
            end else begin
              status_d = rsc_pkg::ST_FULL;
            end
          end
          rsc_pkg::OP_ADD, rsc_pkg::OP_SUB: begin
            if (req_q.op == rsc_pkg::OP_ADD) begin
              sum = {opa[QW-1], opa} + {opb[QW-1], opb};
            end else begin
              sum = {opa[QW-1], opa} - {opb[QW-1], opb};
            end
            // 33-bit result, saturate when the top two bits differ
            if (sum[QW] != sum[QW-1]) begin
              top0_load = sum[QW] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
              status_d  = rsc_pkg::ST_OVF;
            end else begin
              top0_load = sum[QW-1:0];
            end
            cell_cmd = rsc_pkg::CELL_DOWN;
            cnt_d    = cnt_dec;
          end
          rsc_pkg::OP_MUL: begin
            prod_d  = opa * opb;
            done_d  = 1'b0;
            state_d = rsc_pkg::S_MUL;
          end
          rsc_pkg::OP_DIV: begin
            if (opb == '0) begin
              top0_load = opa[QW-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
              status_d  = rsc_pkg::ST_DIV0;
              cell_cmd  = rsc_pkg::CELL_DOWN;
              cnt_d     = cnt_dec;
            end else begin
              div_start = 1'b1;
              done_d    = 1'b0;
              state_d   = rsc_pkg::S_DIV;
            end
          end
          rsc_pkg::OP_DROP: begin
            cell_cmd = rsc_pkg::CELL_DOWN;
            cnt_d    = cnt_dec;
          end
          default: ;
        endcase
      end
      rsc_pkg::S_MUL: begin
        // floor(product / 2^16), saturate unless bits 63..47 agree
        if ((&prod_q[2*QW-1:QW+rsc_pkg::FRAC_W-1]) ||
            !(|prod_q[2*QW-1:QW+rsc_pkg::FRAC_W-1])) begin
          top0_load = prod_q[QW+rsc_pkg::FRAC_W-1:rsc_pkg::FRAC_W];
        end else begin
          top0_load = prod_q[2*QW-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
          status_d  = rsc_pkg::ST_OVF;
        end
        cell_cmd = rsc_pkg::CELL_DOWN;
        cnt_d    = cnt_dec;
        done_d   = 1'b1;
        state_d  = rsc_pkg::S_IDLE;
      end
      rsc_pkg::S_DIV: begin
        if (div_done) begin
          // apply quotient sign, truncation toward zero is kept
          if (opa[QW-1] ^ opb[QW-1]) begin
            if (quot > rsc_pkg::DIV_N_W'(rsc_pkg::Q_MIN)) begin
              top0_load = rsc_pkg::Q_MIN;
              status_d  = rsc_pkg::ST_OVF;
            end else begin
              top0_load = QW'(0) - quot[QW-1:0];
            end
          end else begin
            if (quot > rsc_pkg::DIV_N_W'(rsc_pkg::Q_MAX)) begin
              top0_load = rsc_pkg::Q_MAX;
              status_d  = rsc_pkg::ST_OVF;
            end else begin
              top0_load = quot[QW-1:0];
            end
          end
          cell_cmd = rsc_pkg::CELL_DOWN;
          cnt_d    = cnt_dec;
          done_d   = 1'b1;
          state_d  = rsc_pkg::S_IDLE;
        end
      end
      default: state_d = rsc_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rsc_pkg::S_IDLE;
      status_q <= rsc_pkg::ST_OK;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  // Request capture and product register
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    prod_q <= prod_d;
  end

  // Outputs
  assign cnt_ext           = {4'b0000, cnt_q};
  assign busy              = (state_q != rsc_pkg::S_IDLE);
  assign done_o            = done_q;
  assign res_o.top_value   = cell_data[0];
  assign res_o.stack_depth = cnt_ext[rsc_pkg::DEPTH_OUT_W-1:0];
  assign res_o.status      = status_q;

  // Checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("occupied count beyond stack depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_q == rsc_pkg::ST_FULL) |-> (cnt_q == CntW'(STACK_DEPTH)))
    else $error("full status with room left");

endmodule
`default_nettype wire
